[rtl/core/nngl_pkg.sv]
package nngl_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_POINTS_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int REQ_W     = 2;
  localparam int AXIS_W    = 2;
  localparam int IDX_W     = 4;
  localparam int FIELD_W   = 32;
  localparam int SIZE_W    = 5;
  localparam int DIM_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_COORD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GRID  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  // Axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 2'd3;

  // Configuration codes and reset values
  localparam logic [DIM_W-1:0]  DIMS_TWO       = 2'd2;
  localparam logic [DIM_W-1:0]  DIMS_THREE     = 2'd3;
  localparam logic [SIZE_W-1:0] SIZE_RESET     = 5'd16;

  // Coordinate write command, broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [AXIS_W-1:0] axis;
    logic [IDX_W-1:0]  index;
  } coord_wr_t;

endpackage

[rtl/core/nngl_ram.sv]
module nngl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/nngl_cell.sv]
module nngl_cell #(
  parameter int INDEX = 0,
  parameter int EW    = 32,
  parameter int IW    = 4,
  parameter int CW    = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  nngl_pkg::coord_wr_t      coord_wr,
  input  logic [EW-1:0]            wr_data,
  input  logic [2:0][CW-1:0]       counts,
  input  logic                     valid_in,
  input  logic [2:0][EW-1:0]       q_in,
  input  logic [2:0][EW:0]         best_d_in,
  input  logic [2:0][IW-1:0]       best_i_in,
  output logic                     valid_out,
  output logic [2:0][EW-1:0]       q_out,
  output logic [2:0][EW:0]         best_d_out,
  output logic [2:0][IW-1:0]       best_i_out
);
  import nngl_pkg::*;

  logic [2:0][EW-1:0] coord;
  logic [2:0][EW:0]   diff;
  logic [2:0][EW:0]   mag;
  logic [2:0]         take;
  logic [2:0]         wr_hit;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      diff[l] = {coord[l][EW-1], coord[l]} - {q_in[l][EW-1], q_in[l]};
      mag[l]  = diff[l][EW] ? (~diff[l] + 1'b1) : diff[l];
      // strict compare keeps ties at the lower index
      take[l] = (int'(counts[l]) > INDEX) && (mag[l] < best_d_in[l]);
    end
    wr_hit[0] = coord_wr.en && (coord_wr.axis == AXIS_X) && (int'(coord_wr.index) == INDEX);
    wr_hit[1] = coord_wr.en && (coord_wr.axis == AXIS_Y) && (int'(coord_wr.index) == INDEX);
    wr_hit[2] = coord_wr.en && (coord_wr.axis == AXIS_Z) && (int'(coord_wr.index) == INDEX);
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (wr_hit[l]) begin
        coord[l] <= wr_data;
      end
      q_out[l] <= q_in[l];
      if (take[l]) begin
        best_d_out[l] <= mag[l];
        best_i_out[l] <= IW'(INDEX);
      end else begin
        best_d_out[l] <= best_d_in[l];
        best_i_out[l] <= best_i_in[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

endmodule

[rtl/core/nearest_neighbor_grid_lookup.sv]
// Query path: the query walks the cell chain one cell per cycle, then the RAM read address
// is registered, the grid RAM is read, and the result is registered at the outputs.
// Input is stalled from a query's launch until its result is taken.
// Coordinate and grid write transactions complete in the cycle they are taken.
// Synchronous reset clears control state and the configuration registers;
// coordinate and grid storage hold no defined value until written.
module nearest_neighbor_grid_lookup #(
  parameter int MAX_POINTS = nngl_pkg::MAX_POINTS_DEF,
  parameter int VALUE_BITS = nngl_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [nngl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nngl_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [nngl_pkg::REQ_W-1:0]            req_type,
  input  logic [nngl_pkg::AXIS_W-1:0]           axis,
  input  logic [nngl_pkg::IDX_W-1:0]            point_index,
  input  logic [nngl_pkg::IDX_W-1:0]            grid_ix,
  input  logic [nngl_pkg::IDX_W-1:0]            grid_iy,
  input  logic [nngl_pkg::IDX_W-1:0]            grid_iz,
  input  logic signed [nngl_pkg::FIELD_W-1:0]   load_value,
  input  logic signed [nngl_pkg::FIELD_W-1:0]   query_x,
  input  logic signed [nngl_pkg::FIELD_W-1:0]   query_y,
  input  logic signed [nngl_pkg::FIELD_W-1:0]   query_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [nngl_pkg::FIELD_W-1:0]   grid_value,
  output logic [nngl_pkg::IDX_W-1:0]            nearest_ix,
  output logic [nngl_pkg::IDX_W-1:0]            nearest_iy,
  output logic [nngl_pkg::IDX_W-1:0]            nearest_iz
);
  import nngl_pkg::*;

  localparam int EW    = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int DEPTH = MAX_POINTS * MAX_POINTS * MAX_POINTS;
  localparam int AW    = $clog2(DEPTH);

  // Configuration
  logic [DIM_W-1:0]  dimensions;
  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;
  logic              three;
  logic [2:0][CW-1:0] counts;

  // Control
  logic busy;
  logic in_take;
  logic out_take;
  logic launch;

  // Cell chain, slot 0 is the launch point
  logic [MAX_POINTS:0]               ch_valid;
  logic [MAX_POINTS:0][2:0][EW-1:0]  ch_q;
  logic [MAX_POINTS:0][2:0][EW:0]    ch_best_d;
  logic [MAX_POINTS:0][2:0][IW-1:0]  ch_best_i;

  coord_wr_t coord_wr;

  // Grid path
  logic          grid_wr_en;
  logic [AW-1:0] grid_wr_addr;
  logic          addr_valid;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] nx;
  logic [IW-1:0] ny;
  logic [IW-1:0] nz;
  logic          rd_valid;
  logic [EW-1:0] rd_data;
  logic [IW-1:0] rx;
  logic [IW-1:0] ry;
  logic [IW-1:0] rz;
  logic [IW-1:0] end_iz;

  assign three    = (dimensions == DIMS_THREE);
  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign launch   = in_take && (req_type == REQ_QUERY);

  // Clamp each axis size into 1..MAX_POINTS
  always_comb begin
    counts[0] = (size_x == '0) ? CW'(1) :
                (int'(size_x) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(size_x);
    counts[1] = (size_y == '0) ? CW'(1) :
                (int'(size_y) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(size_y);
    counts[2] = (size_z == '0) ? CW'(1) :
                (int'(size_z) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(size_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions <= DIMS_TWO;
      size_x     <= SIZE_RESET;
      size_y     <= SIZE_RESET;
      size_z     <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DIMENSIONS: dimensions <= cfg_data[DIM_W-1:0];
        CFG_SIZE_X:     size_x     <= cfg_data;
        CFG_SIZE_Y:     size_y     <= cfg_data;
        CFG_SIZE_Z:     size_z     <= cfg_data;
        default:        dimensions <= dimensions;
      endcase
    end
  end

  // Launch: seed the running best with a distance no sample can reach
  always_comb begin
    ch_valid[0]     = launch;
    ch_q[0][0]      = query_x[EW-1:0];
    ch_q[0][1]      = query_y[EW-1:0];
    ch_q[0][2]      = query_z[EW-1:0];
    ch_best_d[0]    = '1;
    ch_best_i[0]    = '0;
    coord_wr.en     = in_take && (req_type == REQ_COORD);
    coord_wr.axis   = axis;
    coord_wr.index  = point_index;
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    nngl_cell #(
      .INDEX (i),
      .EW    (EW),
      .IW    (IW),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .coord_wr   (coord_wr),
      .wr_data    (load_value[EW-1:0]),
      .counts     (counts),
      .valid_in   (ch_valid[i]),
      .q_in       (ch_q[i]),
      .best_d_in  (ch_best_d[i]),
      .best_i_in  (ch_best_i[i]),
      .valid_out  (ch_valid[i+1]),
      .q_out      (ch_q[i+1]),
      .best_d_out (ch_best_d[i+1]),
      .best_i_out (ch_best_i[i+1])
    );
  end

  // Grid writes go straight to the RAM; out-of-range cells are dropped
  always_comb begin
    grid_wr_en = in_take && (req_type == REQ_GRID) &&
                 (int'(grid_ix) < MAX_POINTS) && (int'(grid_iy) < MAX_POINTS) &&
                 (!three || (int'(grid_iz) < MAX_POINTS));
    grid_wr_addr = (AW'(grid_ix) * AW'(MAX_POINTS) + AW'(grid_iy)) * AW'(MAX_POINTS) +
                   (three ? AW'(grid_iz) : '0);
    end_iz = three ? ch_best_i[MAX_POINTS][2] : '0;
  end

  always_ff @(posedge clk) begin
    nx      <= ch_best_i[MAX_POINTS][0];
    ny      <= ch_best_i[MAX_POINTS][1];
    nz      <= end_iz;
    rd_addr <= (AW'(ch_best_i[MAX_POINTS][0]) * AW'(MAX_POINTS) +
                AW'(ch_best_i[MAX_POINTS][1])) * AW'(MAX_POINTS) + AW'(end_iz);
    rx      <= nx;
    ry      <= ny;
    rz      <= nz;
  end

  nngl_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk     (clk),
    .wr_en   (grid_wr_en),
    .wr_addr (grid_wr_addr),
    .wr_data (load_value[EW-1:0]),
    .rd_en   (addr_valid),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      addr_valid <= 1'b0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      addr_valid <= ch_valid[MAX_POINTS];
      rd_valid   <= addr_valid;
      if (launch) begin
        busy <= 1'b1;
      end else if (out_take) begin
        busy <= 1'b0;
      end
      // hold the result until the transaction completes
      if (rd_valid) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      grid_value <= FIELD_W'(signed'(rd_data));
      nearest_ix <= IDX_W'(rx);
      nearest_iy <= IDX_W'(ry);
      nearest_iz <= IDX_W'(rz);
    end
  end

`ifndef SYNTH
  logic [MAX_POINTS+2:0] in_flight;
  assign in_flight = {ch_valid[MAX_POINTS:1], addr_valid, rd_valid, out_valid};

  a_single_query: assert property (@(posedge clk) disable iff (rst)
    $countones(in_flight) <= 1)
    else $error("more than one query in flight");

  a_busy_covers: assert property (@(posedge clk) disable iff (rst)
    (in_flight != '0) |-> busy)
    else $error("query in flight while idle");

  a_launch_blocks: assert property (@(posedge clk) disable iff (rst)
    launch |=> in_stall)
    else $error("input not stalled after query launch");

  a_ix_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(nearest_ix) < int'(counts[0])) || (MAX_POINTS > 16))
    else $error("nearest x index beyond axis size");

  a_iz_two_axes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !three) |-> (nearest_iz == '0))
    else $error("nonzero z index in two-axis mode");
`endif

endmodule

[verif/nearest_neighbor_grid_lookup_tb.sv]
module nearest_neighbor_grid_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nngl_pkg::*;

  localparam int MAX_POINTS    = MAX_POINTS_DEF;
  localparam int ITEM_TARGET   = 1130;
  localparam int PHASE_ITEMS   = 120;
  localparam int SETTLE_CYCLES = MAX_POINTS + 8;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int TIMEOUT_NS    = 5_000_000;

  // codes the block must ignore, and dimension codes that fall back to two axes
  localparam logic [REQ_W-1:0]  REQ_UNUSED    = 2'd3;
  localparam logic [AXIS_W-1:0] AXIS_NONE     = 2'd3;
  localparam logic [DIM_W-1:0]  DIMS_TWO_ALT0 = 2'd0;
  localparam logic [DIM_W-1:0]  DIMS_TWO_ALT1 = 2'd1;

  localparam logic signed [FIELD_W-1:0] V_MIN  = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] V_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] V_ZERO = 32'sh0000_0000;
  localparam logic signed [FIELD_W-1:0] V_NEG1 = 32'shFFFF_FFFF;
  localparam logic signed [FIELD_W-1:0] V_ONE  = 32'sh0001_0000;
  localparam logic signed [FIELD_W-1:0] V_HALF = 32'sh0000_8000;

  typedef struct packed {
    logic [REQ_W-1:0]          kind;
    logic [AXIS_W-1:0]         ax;
    logic [IDX_W-1:0]          pidx;
    logic [IDX_W-1:0]          gx;
    logic [IDX_W-1:0]          gy;
    logic [IDX_W-1:0]          gz;
    logic signed [FIELD_W-1:0] val;
    logic signed [FIELD_W-1:0] qx;
    logic signed [FIELD_W-1:0] qy;
    logic signed [FIELD_W-1:0] qz;
  } lookup_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] value;
    logic [IDX_W-1:0]          ix;
    logic [IDX_W-1:0]          iy;
    logic [IDX_W-1:0]          iz;
  } lookup_res_t;

  typedef struct packed {
    lookup_req_t req;
    bit          chk;
    lookup_res_t want;
  } probe_row_t;

  localparam lookup_res_t NO_RES = '{V_ZERO, 4'd0, 4'd0, 4'd0};

  // Two axes of two samples: x at the extremes, y at 0 and 1.0
  localparam probe_row_t PROBES [22] = '{
    '{'{REQ_COORD, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd0, V_MIN, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_COORD, AXIS_X, 4'd1, 4'd0, 4'd0, 4'd0, V_MAX, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_COORD, AXIS_Y, 4'd0, 4'd0, 4'd0, 4'd0, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_COORD, AXIS_Y, 4'd1, 4'd0, 4'd0, 4'd0, V_ONE, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_GRID, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd15, V_MAX, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_GRID, AXIS_X, 4'd0, 4'd1, 4'd0, 4'd0, V_MIN, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_GRID, AXIS_X, 4'd0, 4'd0, 4'd1, 4'd0, 32'sh1234_5678, V_ZERO, V_ZERO, V_ZERO},
      1'b0, NO_RES},
    '{'{REQ_GRID, AXIS_X, 4'd0, 4'd1, 4'd1, 4'd9, V_NEG1, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_QUERY, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd0, V_ZERO, V_MIN, V_ZERO, V_MAX},
      1'b1, '{V_MAX, 4'd0, 4'd0, 4'd0}},
    '{'{REQ_QUERY, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd0, V_ZERO, V_MAX, V_ONE, V_MIN},
      1'b1, '{V_NEG1, 4'd1, 4'd1, 4'd0}},
    // y exactly halfway between samples: lower index wins
    '{'{REQ_QUERY, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd0, V_ZERO, V_NEG1, V_HALF, V_ZERO},
      1'b1, '{V_MAX, 4'd0, 4'd0, 4'd0}},
    '{'{REQ_QUERY, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd0, V_ZERO, V_ZERO, 32'sh0000_8001, V_ZERO},
      1'b1, '{V_NEG1, 4'd1, 4'd1, 4'd0}},
    '{'{REQ_QUERY, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd0, V_ZERO, V_ZERO, V_MIN, V_NEG1},
      1'b1, '{V_MIN, 4'd1, 4'd0, 4'd0}},
    '{'{REQ_UNUSED, AXIS_Z, 4'd15, 4'd15, 4'd15, 4'd15, V_NEG1, V_NEG1, V_NEG1, V_NEG1},
      1'b0, NO_RES},
    '{'{REQ_COORD, AXIS_NONE, 4'd3, 4'd0, 4'd0, 4'd0, V_MAX, V_ZERO, V_ZERO, V_ZERO},
      1'b0, NO_RES},
    '{'{REQ_COORD, AXIS_X, 4'd15, 4'd0, 4'd0, 4'd0, V_MAX, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_COORD, AXIS_Z, 4'd15, 4'd0, 4'd0, 4'd0, V_MIN, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_GRID, AXIS_X, 4'd0, 4'd15, 4'd15, 4'd15, V_MIN, V_ZERO, V_ZERO, V_ZERO},
      1'b0, NO_RES},
    // equal y samples: lower index wins
    '{'{REQ_COORD, AXIS_Y, 4'd1, 4'd0, 4'd0, 4'd0, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_QUERY, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd0, V_ZERO, V_MIN, V_ONE, V_ZERO},
      1'b1, '{V_MAX, 4'd0, 4'd0, 4'd0}},
    '{'{REQ_GRID, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd0, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b0, NO_RES},
    '{'{REQ_QUERY, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd0, V_ZERO, 32'sh4000_0000, 32'shFFFF_FFFD,
        V_ZERO}, 1'b0, NO_RES}
  };

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [REQ_W-1:0]          req_type = '0;
  logic [AXIS_W-1:0]         axis = '0;
  logic [IDX_W-1:0]          point_index = '0;
  logic [IDX_W-1:0]          grid_ix = '0;
  logic [IDX_W-1:0]          grid_iy = '0;
  logic [IDX_W-1:0]          grid_iz = '0;
  logic signed [FIELD_W-1:0] load_value = '0;
  logic signed [FIELD_W-1:0] query_x = '0;
  logic signed [FIELD_W-1:0] query_y = '0;
  logic signed [FIELD_W-1:0] query_z = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [FIELD_W-1:0] grid_value;
  logic [IDX_W-1:0]          nearest_ix;
  logic [IDX_W-1:0]          nearest_iy;
  logic [IDX_W-1:0]          nearest_iz;

  // shadow of the lookup tables and configuration
  logic signed [FIELD_W-1:0] coord_val [3][MAX_POINTS];
  bit                        coord_set [3][MAX_POINTS];
  logic signed [FIELD_W-1:0] grid_val [MAX_POINTS*MAX_POINTS*MAX_POINTS];
  bit                        grid_set [MAX_POINTS*MAX_POINTS*MAX_POINTS];
  logic [DIM_W-1:0]          dims_reg;
  logic [SIZE_W-1:0]         size_reg [3];

  lookup_res_t pending_lookups [$];
  int          errors = 0;
  int          items_sent = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;

  nearest_neighbor_grid_lookup i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .axis        (axis),
    .point_index (point_index),
    .grid_ix     (grid_ix),
    .grid_iy     (grid_iy),
    .grid_iz     (grid_iz),
    .load_value  (load_value),
    .query_x     (query_x),
    .query_y     (query_y),
    .query_z     (query_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .grid_value  (grid_value),
    .nearest_ix  (nearest_ix),
    .nearest_iy  (nearest_iy),
    .nearest_iz  (nearest_iz)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int axis_span(input int ax);
    int n;
    n = size_reg[ax];
    return (n == 0) ? 1 : ((n > MAX_POINTS) ? MAX_POINTS : n);
  endfunction

  function automatic logic [IDX_W-1:0] nearest_index(input int ax,
                                                     input logic signed [FIELD_W-1:0] q);
    logic [IDX_W-1:0] best;
    longint           d;
    longint           best_d;
    best = '0;
    best_d = longint'(coord_val[ax][0]) - longint'(q);
    if (best_d < 0) best_d = -best_d;
    for (int i = 1; i < axis_span(ax); i++) begin
      d = longint'(coord_val[ax][i]) - longint'(q);
      if (d < 0) d = -d;
      // strict compare keeps the lowest index on a tie
      if (d < best_d) begin
        best_d = d;
        best = IDX_W'(i);
      end
    end
    return best;
  endfunction

  // Update the shadow state for one accepted transaction; 1 if it yields a lookup
  function automatic bit apply_request(input lookup_req_t r, output lookup_res_t res);
    bit                 three;
    logic [3*IDX_W-1:0] slot;
    three = (dims_reg == DIMS_THREE);
    res = '0;
    apply_request = 1'b0;
    case (r.kind)
      REQ_COORD: begin
        if (r.ax != AXIS_NONE) begin
          coord_val[r.ax][r.pidx] = r.val;
          coord_set[r.ax][r.pidx] = 1'b1;
        end
      end
      REQ_GRID: begin
        slot = {r.gx, r.gy, three ? r.gz : 4'd0};
        grid_val[slot] = r.val;
        grid_set[slot] = 1'b1;
      end
      REQ_QUERY: begin
        res.ix = nearest_index(0, r.qx);
        res.iy = nearest_index(1, r.qy);
        res.iz = three ? nearest_index(2, r.qz) : 4'd0;
        res.value = grid_val[{res.ix, res.iy, res.iz}];
        apply_request = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic lookup_req_t random_req();
    lookup_req_t r;
    r.kind = REQ_W'($urandom);
    r.ax   = AXIS_W'($urandom);
    r.pidx = IDX_W'($urandom);
    r.gx   = IDX_W'($urandom);
    r.gy   = IDX_W'($urandom);
    r.gz   = IDX_W'($urandom);
    r.val  = $urandom;
    r.qx   = $urandom;
    r.qy   = $urandom;
    r.qz   = $urandom;
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0: return V_MIN;
      1: return V_MAX;
      2: return V_ZERO;
      default: return V_NEG1;
    endcase
  endfunction

  // ax < 0: no reuse of an existing sample
  function automatic logic signed [FIELD_W-1:0] pick_sample(input int ax);
    int j;
    j = $urandom_range(0, MAX_POINTS - 1);
    case ($urandom_range(0, 7))
      0: return extreme_value();
      1, 2, 3: return $signed($urandom_range(0, 'h6_0000)) - 32'sh3_0000;
      4, 5: return $urandom;
      default: return (ax >= 0 && coord_set[ax][j]) ? coord_val[ax][j] : $urandom;
    endcase
  endfunction

  // Aim near samples and at midpoints so ties and close calls show up
  function automatic logic signed [FIELD_W-1:0] aim_query(input int ax);
    int     i;
    int     j;
    longint s;
    i = $urandom_range(0, axis_span(ax) - 1);
    j = $urandom_range(0, axis_span(ax) - 1);
    case ($urandom_range(0, 7))
      0: return extreme_value();
      1, 2: return $urandom;
      3, 4, 5: return coord_val[ax][i] + $signed($urandom_range(0, 6)) - 32'sd3;
      default: begin
        s = longint'(coord_val[ax][i]) + longint'(coord_val[ax][j]);
        return FIELD_W'(s >>> 1);
      end
    endcase
  endfunction

  task automatic send_txn(input lookup_req_t r, input bit typed = 1'b0,
                          input lookup_res_t want = '0);
    lookup_res_t predicted;
    bit          hit;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= r.kind;
    axis        <= r.ax;
    point_index <= r.pidx;
    grid_ix     <= r.gx;
    grid_iy     <= r.gy;
    grid_iz     <= r.gz;
    load_value  <= r.val;
    query_x     <= r.qx;
    query_y     <= r.qy;
    query_z     <= r.qz;
    do @(posedge clk); while (in_stall !== 1'b0);
    hit = apply_request(r, predicted);
    if (hit) pending_lookups.push_back(typed ? want : predicted);
    if (r.kind != REQ_UNUSED && !(r.kind == REQ_COORD && r.ax == AXIS_NONE)) items_sent++;
  endtask

  // Load any sample and grid cell the query would touch, then issue it
  task automatic issue_query();
    lookup_req_t      r;
    lookup_req_t      w;
    bit               three;
    logic [IDX_W-1:0] nx;
    logic [IDX_W-1:0] ny;
    logic [IDX_W-1:0] nz;
    three = (dims_reg == DIMS_THREE);
    for (int ax = 0; ax < (three ? 3 : 2); ax++) begin
      for (int i = 0; i < axis_span(ax); i++) begin
        if (!coord_set[ax][i]) begin
          w = random_req();
          w.kind = REQ_COORD;
          w.ax = AXIS_W'(ax);
          w.pidx = IDX_W'(i);
          w.val = pick_sample(-1);
          send_txn(w);
        end
      end
    end
    r = random_req();
    r.kind = REQ_QUERY;
    r.qx = aim_query(0);
    r.qy = aim_query(1);
    if (three) r.qz = aim_query(2);
    nx = nearest_index(0, r.qx);
    ny = nearest_index(1, r.qy);
    nz = three ? nearest_index(2, r.qz) : 4'd0;
    if (!grid_set[{nx, ny, nz}]) begin
      w = random_req();
      w.kind = REQ_GRID;
      w.gx = nx;
      w.gy = ny;
      if (three) w.gz = nz;
      w.val = pick_sample(-1);
      send_txn(w);
    end
    send_txn(r);
  endtask

  task automatic random_step();
    lookup_req_t r;
    r = random_req();
    case ($urandom_range(0, 19))
      10, 11, 12, 13: begin
        r.kind = REQ_COORD;
        r.ax = AXIS_W'($urandom_range(0, 2));
        r.val = pick_sample(r.ax);
        send_txn(r);
      end
      14, 15, 16: begin
        r.kind = REQ_GRID;
        r.val = pick_sample(-1);
        send_txn(r);
      end
      17: begin
        r.kind = REQ_UNUSED;
        send_txn(r);
      end
      18: begin
        r.kind = REQ_COORD;
        r.ax = AXIS_NONE;
        send_txn(r);
      end
      default: issue_query();
    endcase
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return SIZE_W'($urandom_range(17, 31));
      default: return SIZE_W'($urandom_range(2, 15));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_config(input logic [DIM_W-1:0] dims, input logic [SIZE_W-1:0] sx,
                                input logic [SIZE_W-1:0] sy, input logic [SIZE_W-1:0] sz);
    // upper data bits are don't-care for the dimension register
    write_reg(CFG_DIMENSIONS, {3'($urandom), dims});
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    dims_reg = dims;
    size_reg[0] = sx;
    size_reg[1] = sy;
    size_reg[2] = sz;
  endtask

  // Hold input, drain outstanding lookups, then let the pipeline go quiet
  task automatic quiesce();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_lookups.size() != 0) begin
      log_mismatch($sformatf("%0d lookups never returned", pending_lookups.size()));
      pending_lookups.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    lookup_res_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_lookups.size() == 0) begin
        log_mismatch("result transaction with no query outstanding");
      end else begin
        want = pending_lookups.pop_front();
        if (grid_value !== want.value)
          log_mismatch($sformatf("grid_value got %h want %h", grid_value, want.value));
        if (nearest_ix !== want.ix)
          log_mismatch($sformatf("nearest_ix got %0d want %0d", nearest_ix, want.ix));
        if (nearest_iy !== want.iy)
          log_mismatch($sformatf("nearest_iy got %0d want %0d", nearest_iy, want.iy));
        if (nearest_iz !== want.iz)
          log_mismatch($sformatf("nearest_iz got %0d want %0d", nearest_iz, want.iz));
      end
    end
    if (rst || !idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int phase;
    int goal;
    dims_reg = DIMS_TWO;
    size_reg = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_config(DIMS_TWO, 5'd2, 5'd2, 5'd1);
    foreach (PROBES[k]) send_txn(PROBES[k].req, PROBES[k].chk, PROBES[k].want);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      // last phase runs with no gaps or stalls
      idle_on <= (items_sent < ITEM_TARGET - PHASE_ITEMS);
      quiesce();
      case (phase)
        0: program_config(DIMS_THREE, 5'd1, 5'd1, 5'd1);
        1: program_config(DIMS_THREE, 5'd16, 5'd16, 5'd16);
        2: program_config(DIMS_TWO_ALT0, 5'd0, 5'd31, 5'd7);
        3: program_config(DIMS_TWO_ALT1, 5'd17, 5'd3, 5'd0);
        4: program_config(DIMS_TWO, 5'd16, 5'd1, 5'd16);
        default: begin
          program_config(($urandom_range(0, 2) != 0) ? DIMS_THREE : DIM_W'($urandom_range(0, 2)),
                         pick_size(), pick_size(), pick_size());
        end
      endcase
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) random_step();
      phase++;
    end

    quiesce();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[nearest_neighbor_grid_lookup.f]
rtl/core/nngl_pkg.sv
rtl/core/nngl_ram.sv
rtl/core/nngl_cell.sv
rtl/core/nearest_neighbor_grid_lookup.sv
verif/nearest_neighbor_grid_lookup_tb.sv
